FILE: sv/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types and constants of the filled-circle span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsg_pkg;

	// Offsets carry the radius, at most 63, and a y of -1 on the closing step.
	localparam int OFS_W = 8;
	localparam int DEC_W = 12;
	localparam int POS_W = 12;
	localparam int CX_W  = 10;
	localparam int RAD_W = 6;
	localparam int COL_W = 2;

	localparam int RES_LIMIT = 64;
	localparam int CNT_W     = $clog2(RES_LIMIT);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [0:0] {
		OP_FILL_CIRCLE = 1'b0
	} op_t;

	typedef struct packed {
		logic [CX_W-1:0]         cx;
		logic [CX_W-1:0]         cy;
		logic signed [OFS_W-1:0] rad;
		logic signed [DEC_W-1:0] dec0;
		logic [COL_W-1:0]        colour;
	} cmd_t;

	typedef struct packed {
		logic signed [POS_W-1:0] row_a_low;
		logic signed [POS_W-1:0] row_a_high;
		logic signed [POS_W-1:0] span_a_left;
		logic signed [POS_W-1:0] span_a_right;
		logic signed [POS_W-1:0] row_b_low;
		logic signed [POS_W-1:0] row_b_high;
		logic signed [POS_W-1:0] span_b_left;
		logic signed [POS_W-1:0] span_b_right;
		logic [COL_W-1:0]        colour;
		logic                    last;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

FILE: sv/fcsg_front.sv
// ----------------------------------------------------------------------------
// fcsg_front
// Decodes an incoming command: clamps the radius and forms the starting
// decision term.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsg_front
	import fcsg_pkg::*;
#(
	parameter int MAX_RADIUS = 63
) (
	input  wire logic [CX_W-1:0]  center_x,
	input  wire logic [CX_W-1:0]  center_y,
	input  wire logic [RAD_W-1:0] radius,
	input  wire logic             func,
	input  wire logic [COL_W-1:0] colour,
	output cmd_t                  cmd
);

	logic [OFS_W-1:0] rad_ext;
	logic [OFS_W-1:0] rad_clamped;

	assign rad_ext = OFS_W'(radius);

	always_comb begin
		// Every opcode is a filled circle; unknown codes take the same path.
		case (op_t'(func))
			OP_FILL_CIRCLE: rad_clamped = rad_ext;
			default:        rad_clamped = rad_ext;
		endcase
		if (rad_clamped > OFS_W'(MAX_RADIUS)) begin
			rad_clamped = OFS_W'(MAX_RADIUS);
		end
		cmd.cx     = center_x;
		cmd.cy     = center_y;
		cmd.rad    = $signed(rad_clamped);
		cmd.dec0   = DEC_W'(3) - (DEC_W'(rad_clamped) << 1);
		cmd.colour = colour;
	end

endmodule

`default_nettype wire

FILE: sv/fcsg_cmd_queue.sv
// ----------------------------------------------------------------------------
// fcsg_cmd_queue
// Short command queue between the decoder and the span stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsg_cmd_queue
	import fcsg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head_cmd,
	output q_status_t status
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/fcsg_back.sv
// ----------------------------------------------------------------------------
// fcsg_back
// Midpoint circle stepper: walks one octant and registers one set of four
// spans per step.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsg_back
	import fcsg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_t      head_cmd,
	input  wire q_status_t q_status,
	output logic           pop,
	output res_t           res,
	output logic           res_valid,
	input  wire logic      res_stall
);

	logic                    busy_q;
	logic signed [OFS_W-1:0] x_q;
	logic signed [OFS_W-1:0] y_q;
	logic signed [DEC_W-1:0] d_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CX_W-1:0]         cx_q;
	logic [CX_W-1:0]         cy_q;
	logic [COL_W-1:0]        colour_q;

	logic                    out_valid_q;
	res_t                    out_q;

	logic                    emit;
	logic                    last;
	logic signed [OFS_W-1:0] x_nx;
	logic signed [OFS_W-1:0] y_nx;
	logic signed [DEC_W-1:0] d_nx;
	logic signed [POS_W-1:0] cxp;
	logic signed [POS_W-1:0] cyp;
	logic signed [POS_W-1:0] xp;
	logic signed [POS_W-1:0] yp;
	logic signed [POS_W-1:0] a0;
	logic signed [POS_W-1:0] a1;
	logic signed [POS_W-1:0] b0;
	logic signed [POS_W-1:0] b1;
	res_t                    res_nx;

	assign emit = busy_q && (!out_valid_q || !res_stall);
	assign pop  = !busy_q && !q_status.empty;
	// Close after the first step with y below x, or on the result limit.
	assign last = (y_q < x_q) || (cnt_q == CNT_W'(RES_LIMIT - 1));

	always_comb begin
		x_nx = x_q + OFS_W'(1);
		if (d_q > 0) begin
			y_nx = y_q - OFS_W'(1);
			d_nx = d_q + ((DEC_W'(x_nx) - DEC_W'(y_nx)) <<< 2) + DEC_W'(10);
		end else begin
			y_nx = y_q;
			d_nx = d_q + (DEC_W'(x_nx) <<< 2) + DEC_W'(6);
		end
	end

	always_comb begin
		cxp = $signed(POS_W'(cx_q));
		cyp = $signed(POS_W'(cy_q));
		xp  = POS_W'(x_q);
		yp  = POS_W'(y_q);
		a0  = cxp - xp;
		a1  = cxp + xp;
		b0  = cxp - yp;
		b1  = cxp + yp;
		res_nx.row_a_low    = cyp - yp;
		res_nx.row_a_high   = cyp + yp;
		res_nx.span_a_left  = (a0 > a1) ? a1 : a0;
		res_nx.span_a_right = (a0 > a1) ? a0 : a1;
		res_nx.row_b_low    = cyp - xp;
		res_nx.row_b_high   = cyp + xp;
		res_nx.span_b_left  = (b0 > b1) ? b1 : b0;
		res_nx.span_b_right = (b0 > b1) ? b0 : b1;
		res_nx.colour       = colour_q;
		res_nx.last         = last;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cx_q     <= head_cmd.cx;
			cy_q     <= head_cmd.cy;
			colour_q <= head_cmd.colour;
			x_q      <= '0;
			y_q      <= head_cmd.rad;
			d_q      <= head_cmd.dec0;
		end else if (emit) begin
			x_q <= x_nx;
			y_q <= y_nx;
			d_q <= d_nx;
		end
		if (emit) begin
			out_q <= res_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (emit) begin
				busy_q <= !last;
				cnt_q  <= cnt_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: sv/filled_circle_span_generator.sv
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Filled-circle command in, one registered set of four horizontal spans out
// for every midpoint step of the circle.
// ----------------------------------------------------------------------------
// Each command (centre, radius, colour) yields the spans of a filled circle,
// one result word per midpoint step, the starting point included; the last
// word of a command carries last_step. A radius above MAX_RADIUS is clamped.
// Right span ends are the larger bound and left ends are the smaller bound. A
// command of clamped radius r gives about r/sqrt(2) + 2 words (two for radius
// zero, at most 64), one per clock while the output is not stalled, after the
// command is loaded into the stepper's x/y/decision registers. A two-word
// command queue sits between the decoder and the stepper, so the next command
// is taken while the current circle is still being walked.
`default_nettype none

module filled_circle_span_generator
	import fcsg_pkg::*;
#(
	parameter int MAX_RADIUS = 63
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CX_W-1:0]   center_x,
	input  wire logic [CX_W-1:0]   center_y,
	input  wire logic [RAD_W-1:0]  radius,
	input  wire logic              func,
	input  wire logic [COL_W-1:0]  colour,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [POS_W-1:0] row_a_low,
	output logic signed [POS_W-1:0] row_a_high,
	output logic signed [POS_W-1:0] span_a_left,
	output logic signed [POS_W-1:0] span_a_right,
	output logic signed [POS_W-1:0] row_b_low,
	output logic signed [POS_W-1:0] row_b_high,
	output logic signed [POS_W-1:0] span_b_left,
	output logic signed [POS_W-1:0] span_b_right,
	output logic [COL_W-1:0]       span_colour,
	output logic                   last_step
);

	cmd_t      dec_cmd;
	cmd_t      head_cmd;
	q_status_t q_status;
	logic      push;
	logic      pop;
	res_t      res;

	// Decode: clamp the radius and form the first decision term.
	fcsg_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.center_x(center_x),
		.center_y(center_y),
		.radius  (radius),
		.func    (func),
		.colour  (colour),
		.cmd     (dec_cmd)
	);

	// Hold off the source only while the queue is full.
	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	fcsg_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(dec_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.status  (q_status)
	);

	// Walk the octant; the output register parts the stepper from the sink.
	fcsg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_status (q_status),
		.pop      (pop),
		.res      (res),
		.res_valid(out_valid),
		.res_stall(out_stall)
	);

	assign row_a_low    = res.row_a_low;
	assign row_a_high   = res.row_a_high;
	assign span_a_left  = res.span_a_left;
	assign span_a_right = res.span_a_right;
	assign row_b_low    = res.row_b_low;
	assign row_b_high   = res.row_b_high;
	assign span_b_left  = res.span_b_left;
	assign span_b_right = res.span_b_right;
	assign span_colour  = res.colour;
	assign last_step    = res.last;

endmodule

`default_nettype wire
